[rtl/rpa_pkg.sv]
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes of the Ryser permanent amplitude block.
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int MAX_ORBITALS        = 64;
	localparam int MAX_EXCITATIONS_DEF = 8;
	localparam int PARAM_DEPTH_DEF     = 1024;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_AMP   = 2'd1;
	localparam logic [1:0] KIND_DERIV = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EXC   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic REG_OCC  = 1'b0;
	localparam logic REG_NORB = 1'b1;

	localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;

	typedef struct packed {
		logic [1:0]         kind;
		logic [63:0]        occupation_mask;
		logic [5:0]         param_row;
		logic [5:0]         param_col;
		logic signed [31:0] param_value;
	} item_t;

	typedef struct packed {
		logic signed [63:0] amplitude;
		logic [1:0]         status;
	} result_t;

endpackage

[rtl/ryser_permanent_amplitude.sv]
// ----------------------------------------------------------------------------
// ryser_permanent_amplitude
// Parameter matrix store and Ryser permanent evaluator for excitation masks.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we/cfg_index/cfg_data write occupied_count (index 0)
//   or orbital_count (index 1); only while busy is low.
//   Command: a beat is taken when start is high and busy is low. busy stays
//   high until the result beat, which is shown on result with done high for
//   exactly one cycle; the receiver cannot stall it.
//   Writes and unused kinds: result beat in the cycle right after the start
//   beat; a new command is taken once busy is low again.
//   Queries: the mask is scanned one orbital a cycle, then a decision state;
//   for m excitations (2^m - 1) subsets follow. For each subset, per row the
//   RAM reads are summed into the row sum, then the shared 32x32 multiplier
//   forms four partial products and a finishing state stores the rounded
//   product; each subset ends with an accumulate state. The single RAM read
//   port and the one multiplier set the query time.
//   Reset: registers go to occupied_count 1, orbital_count 64, idle. The
//   matrix is not cleared and holds nothing until written.
// ----------------------------------------------------------------------------
module ryser_permanent_amplitude #(
	parameter int MAX_EXCITATIONS = rpa_pkg::MAX_EXCITATIONS_DEF,
	parameter int PARAM_DEPTH     = rpa_pkg::PARAM_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data,
	input  rpa_pkg::item_t   item,
	output logic             done,
	output rpa_pkg::result_t result
);

	import rpa_pkg::*;

	localparam int ME  = MAX_EXCITATIONS;
	localparam int AW  = $clog2(PARAM_DEPTH);
	localparam int CW  = $clog2(ME + 1);
	localparam int IW  = (ME > 1) ? $clog2(ME) : 1;
	localparam int RSW = 32 + $clog2(ME) + 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DECIDE = 8'b0000_0100,
		S_ROW    = 8'b0000_1000,
		S_MUL    = 8'b0001_0000,
		S_FIN    = 8'b0010_0000,
		S_ACC    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [5:0]  occ_q;
	logic [6:0]  norb_q;
	logic [1:0]  kind_q;
	logic [5:0]  r_q, c_q;
	logic [63:0] holes_q, parts_q;
	logic [5:0]  b_q;
	logic [6:0]  nh_q, np_q;
	logic [CW-1:0] lh_q, lp_q;
	logic        found_r_q, found_c_q;
	logic [5:0]  last_row_q, last_col_q;
	logic [5:0]  rows_q [ME];
	logic [5:0]  cols_q [ME];
	logic [CW-1:0] m_q, i_q, jc_q;
	logic [ME-1:0] subset_q;
	logic        pend_q, pbit_q;
	logic [RSW-1:0] rs_q;
	logic [63:0] prod_q, acc_q, xm_q, ym_q;
	logic        neg_q, sat_q;
	logic [2:0]  ph_q;
	logic [127:0] pacc_q;
	logic [63:0] amp_q;
	logic [1:0]  st_q;

	// derived configuration
	logic [6:0]  norb_c, nc_c;
	logic [63:0] valid_c, ref_c, mask_c;

	always_comb begin
		norb_c  = (norb_q > 7'(MAX_ORBITALS)) ? 7'(MAX_ORBITALS) : norb_q;
		nc_c    = (norb_c > {1'b0, occ_q}) ? norb_c - {1'b0, occ_q} : 7'd0;
		valid_c = (norb_c >= 7'd64) ? '1 : (64'd1 << norb_c[5:0]) - 64'd1;
		ref_c   = ((64'd1 << occ_q) - 64'd1) & valid_c;
		mask_c  = item.occupation_mask & valid_c;
	end

	// matrix addressing
	logic [12:0] waddr_full, raddr_full, chk_full;
	logic        wr_bad, chk_bad, wr_en;
	logic [31:0] ram_rdata;

	always_comb begin
		waddr_full = 13'({7'd0, item.param_row} * {6'd0, nc_c}) + {7'd0, item.param_col};
		raddr_full = 13'({7'd0, rows_q[0]} * {6'd0, nc_c}) + {7'd0, cols_q[0]};
		chk_full   = 13'({7'd0, last_row_q} * {6'd0, nc_c}) + {7'd0, last_col_q};
		wr_bad = (item.param_row >= occ_q) || ({1'b0, item.param_col} >= nc_c) ||
			({19'd0, waddr_full} >= 32'(PARAM_DEPTH));
		chk_bad = {19'd0, chk_full} >= 32'(PARAM_DEPTH);
		wr_en = (state_q == S_IDLE) && start && (item.kind == KIND_WRITE) && !wr_bad;
	end

	rpa_ram #(
		.WIDTH (32),
		.DEPTH (PARAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr_full[AW-1:0]),
		.wdata (item.param_value),
		.raddr (raddr_full[AW-1:0]),
		.rdata (ram_rdata)
	);

	// multiplier and rounding
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [63:0]  rs_ext, limit_c, qmag_c, prod_next;
	logic [97:0]  q_c;
	logic         mul_sat;

	always_comb begin
		rs_ext = {{(64-RSW){rs_q[RSW-1]}}, rs_q};
		mul_a  = (ph_q == 3'd3 || ph_q == 3'd4) ? xm_q[63:32] : xm_q[31:0];
		mul_b  = (ph_q == 3'd2 || ph_q == 3'd4) ? ym_q[63:32] : ym_q[31:0];
		pp     = {32'd0, mul_a} * {32'd0, mul_b};
		case (ph_q)
			3'd1:    pp_sh = {64'd0, pp};
			3'd2:    pp_sh = {32'd0, pp, 32'd0};
			3'd3:    pp_sh = {32'd0, pp, 32'd0};
			3'd4:    pp_sh = {pp, 64'd0};
			default: pp_sh = '0;
		endcase
		q_c       = pacc_q[127:30];
		limit_c   = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		mul_sat   = (|q_c[97:64]) || (q_c[63:0] > limit_c);
		qmag_c    = mul_sat ? limit_c : q_c[63:0];
		prod_next = neg_q ? 64'd0 - qmag_c : qmag_c;
	end

	// sign and accumulate
	logic [63:0] term_c, acc_next;
	logic        term_sat, add_sat;
	logic [64:0] sum_c;
	logic [ME:0] full_c;

	always_comb begin
		term_sat = 1'b0;
		term_c   = prod_q;
		if ((^subset_q) ^ m_q[0]) begin
			if (prod_q == 64'h8000_0000_0000_0000) begin
				term_c   = 64'h7FFF_FFFF_FFFF_FFFF;
				term_sat = 1'b1;
			end else begin
				term_c = 64'd0 - prod_q;
			end
		end
		sum_c    = {term_c[63], term_c} + {acc_q[63], acc_q};
		add_sat  = sum_c[64] != sum_c[63];
		acc_next = add_sat ? (sum_c[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
			: sum_c[63:0];
		full_c   = ({{ME{1'b0}}, 1'b1} << m_q) - 1'b1;
	end

	logic       deriv_c;
	logic [5:0] pcol_c;
	assign deriv_c = kind_q == KIND_DERIV;
	assign pcol_c  = b_q - occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= 6'd1;
			norb_q  <= 7'd64;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OCC:  occ_q  <= cfg_data[5:0];
					REG_NORB: norb_q <= cfg_data;
					default:  ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q    <= item.kind;
						r_q       <= item.param_row;
						c_q       <= item.param_col;
						holes_q   <= ref_c & ~mask_c;
						parts_q   <= mask_c & ~ref_c;
						b_q       <= '0;
						nh_q      <= '0;
						np_q      <= '0;
						lh_q      <= '0;
						lp_q      <= '0;
						found_r_q <= 1'b0;
						found_c_q <= 1'b0;
						amp_q     <= '0;
						st_q      <= ST_OK;
						case (item.kind)
							KIND_WRITE: begin
								st_q    <= wr_bad ? ST_RANGE : ST_OK;
								state_q <= S_DONE;
							end
							KIND_AMP, KIND_DERIV: state_q <= S_SCAN;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					holes_q <= holes_q >> 1;
					parts_q <= parts_q >> 1;
					b_q     <= b_q + 6'd1;
					if (holes_q[0]) begin
						nh_q <= nh_q + 7'd1;
						if (deriv_c && b_q == r_q) begin
							found_r_q <= 1'b1;
						end else if (lh_q < CW'(ME)) begin
							rows_q[lh_q[IW-1:0]] <= b_q;
							last_row_q <= b_q;
							lh_q <= lh_q + 1'b1;
						end
					end
					if (parts_q[0]) begin
						np_q <= np_q + 7'd1;
						if (deriv_c && pcol_c == c_q) begin
							found_c_q <= 1'b1;
						end else if (lp_q < CW'(ME)) begin
							cols_q[lp_q[IW-1:0]] <= pcol_c;
							last_col_q <= pcol_c;
							lp_q <= lp_q + 1'b1;
						end
					end
					if (b_q == 6'd63) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q  <= S_DONE;
					m_q      <= lh_q;
					subset_q <= {{(ME-1){1'b0}}, 1'b1};
					prod_q   <= ONE_Q30;
					acc_q    <= '0;
					sat_q    <= 1'b0;
					i_q      <= '0;
					jc_q     <= '0;
					rs_q     <= '0;
					pend_q   <= 1'b0;
					if (nh_q != np_q) begin
						st_q <= ST_RANGE;
					end else if (nh_q > 7'(ME)) begin
						st_q <= ST_EXC;
					end else if (kind_q == KIND_DERIV && (r_q >= occ_q ||
						{1'b0, c_q} >= nc_c)) begin
						st_q <= ST_RANGE;
					end else if (kind_q == KIND_DERIV && (nh_q == 7'd0 ||
						!(found_r_q && found_c_q))) begin
						st_q <= ST_OK;
					end else if (lh_q == '0) begin
						amp_q <= ONE_Q30;
					end else if (chk_bad) begin
						st_q <= ST_RANGE;
					end else begin
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					if (pend_q && pbit_q) begin
						rs_q <= rs_q + {{(RSW-32){ram_rdata[31]}}, ram_rdata};
					end
					if (jc_q < m_q) begin
						for (int k = 0; k < ME; k++) begin
							if (CW'(k) == m_q - 1'b1) begin
								cols_q[k] <= cols_q[0];
							end else if (CW'(k) < m_q - 1'b1) begin
								cols_q[k] <= cols_q[(k + 1) % ME];
							end
						end
						pend_q <= 1'b1;
						pbit_q <= subset_q[jc_q[IW-1:0]];
						jc_q   <= jc_q + 1'b1;
					end else begin
						pend_q  <= 1'b0;
						ph_q    <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (ph_q == 3'd0) begin
						xm_q   <= prod_q[63] ? 64'd0 - prod_q : prod_q;
						ym_q   <= rs_ext[63] ? 64'd0 - rs_ext : rs_ext;
						neg_q  <= prod_q[63] ^ rs_ext[63];
						pacc_q <= 128'd1 << 29; // rounding, half away from zero
					end else begin
						pacc_q <= pacc_q + pp_sh;
					end
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd4) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					prod_q <= prod_next;
					sat_q  <= sat_q | mul_sat;
					for (int k = 0; k < ME; k++) begin
						if (CW'(k) == m_q - 1'b1) begin
							rows_q[k] <= rows_q[0];
						end else if (CW'(k) < m_q - 1'b1) begin
							rows_q[k] <= rows_q[(k + 1) % ME];
						end
					end
					i_q  <= i_q + 1'b1;
					jc_q <= '0;
					rs_q <= '0;
					state_q <= (i_q + 1'b1 == m_q) ? S_ACC : S_ROW;
				end
				S_ACC: begin
					acc_q  <= acc_next;
					prod_q <= ONE_Q30;
					i_q    <= '0;
					if (subset_q == full_c[ME-1:0]) begin
						amp_q   <= acc_next;
						st_q    <= (sat_q | term_sat | add_sat) ? ST_SAT : ST_OK;
						state_q <= S_DONE;
					end else begin
						sat_q    <= sat_q | term_sat | add_sat;
						subset_q <= subset_q + 1'b1;
						state_q  <= S_ROW;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
	assign result.amplitude = amp_q;
	assign result.status    = st_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("command beat not taken");

	a_row_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW) |-> (m_q != '0 && jc_q <= m_q && i_q < m_q))
		else $error("row sequencer out of range");

endmodule

[rtl/rpa_ram.sv]
// ----------------------------------------------------------------------------
// rpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[tb/tb_ryser_permanent_amplitude.sv]
// ----------------------------------------------------------------------------
// tb_ryser_permanent_amplitude
// Self-checking bench: directed table then random masks over several orbital
// geometries, each result beat checked against a typed expectation or a bit-exact permanent model.
// ----------------------------------------------------------------------------
module tb_ryser_permanent_amplitude;
	timeunit 1ns;
	timeprecision 1ps;
	import rpa_pkg::*;

	localparam int DEPTH         = PARAM_DEPTH_DEF;
	localparam int MAX_EXC       = MAX_EXCITATIONS_DEF;
	localparam int WDOG_MAX      = 200000;
	localparam int ITEMS_PER_GEO = 26;
	localparam longint Q_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint Q_MIN = 64'sh8000_0000_0000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_OCC;
	logic [6:0]  cfg_data = '0;
	item_t       item = '0;
	logic        done;
	result_t     result;

	ryser_permanent_amplitude i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.done      (done),
		.result    (result)
	);

	always #10 clk = ~clk;

	// model state
	logic [31:0] param_mem [DEPTH];
	bit          param_written [DEPTH];
	int          occ_cfg = 1;
	int          norb_cfg = 64;

	result_t     pending_amplitudes [$];
	int          mismatch_count = 0;
	int          idle_cycles = 0;
	int          issued_count = 0;
	bit          gaps_on = 1'b1;

	task automatic report(input string what);
		$display("[%0t] MISMATCH %s", $time, what);
		mismatch_count++;
	endtask

	function automatic int column_count();
		int n;
		n = norb_cfg > 64 ? 64 : norb_cfg;
		return n > occ_cfg ? n - occ_cfg : 0;
	endfunction

	function automatic void split_mask(input logic [63:0] mask, output int nh, output int np,
			output int hl [64], output int pl [64]);
		int n;
		logic [63:0] valid, refdet, holes, parts;
		n = norb_cfg > 64 ? 64 : norb_cfg;
		valid = n >= 64 ? '1 : ((64'd1 << n) - 64'd1);
		refdet = ((64'd1 << occ_cfg) - 64'd1) & valid;
		holes = refdet & ~(mask & valid);
		parts = (mask & valid) & ~refdet;
		nh = 0;
		np = 0;
		for (int b = 0; b < 64; b++) begin
			if (holes[b]) begin
				hl[nh] = b;
				nh++;
			end
			if (parts[b]) begin
				pl[np] = b - occ_cfg;
				np++;
			end
		end
	endfunction

	function automatic longint mul_q30(input longint a, input longint b, inout bit sat);
		bit neg;
		logic [63:0] x, y, lim;
		logic [127:0] p;
		neg = (a < 0) != (b < 0);
		x = a < 0 ? -a : a;
		y = b < 0 ? -b : b;
		p = {64'd0, x} * {64'd0, y} + (128'd1 << 29);
		p = p >> 30;
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		if (p > {64'd0, lim}) begin
			sat = 1'b1;
			p = {64'd0, lim};
		end
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint add_sat(input longint a, input longint b, inout bit sat);
		longint s;
		s = a + b;
		if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) begin
			sat = 1'b1;
			return a < 0 ? Q_MIN : Q_MAX;
		end
		return s;
	endfunction

	function automatic logic [1:0] ryser_sum(input int rows [64], input int cols [64],
			input int m, output longint amp);
		int nc, bits;
		longint acc, prod, rs;
		bit sat;
		nc = column_count();
		amp = 0;
		for (int i = 0; i < m; i++)
			for (int j = 0; j < m; j++)
				if (rows[i] * nc + cols[j] >= DEPTH) return ST_RANGE;
		acc = 0;
		sat = 1'b0;
		for (int s = 1; s < (1 << m); s++) begin
			prod = longint'(ONE_Q30);
			bits = $countones(s);
			for (int i = 0; i < m; i++) begin
				rs = 0;
				for (int j = 0; j < m; j++)
					if (s[j]) rs += longint'($signed(param_mem[rows[i] * nc + cols[j]]));
				prod = mul_q30(prod, rs, sat);
			end
			if ((bits + m) % 2 == 1) begin
				if (prod == Q_MIN) begin
					sat = 1'b1;
					prod = Q_MAX;
				end else begin
					prod = -prod;
				end
			end
			acc = add_sat(acc, prod, sat);
		end
		amp = acc;
		return sat ? ST_SAT : ST_OK;
	endfunction

	// expected result of one beat; updates the matrix on writes
	function automatic result_t compute_amplitude(input item_t it);
		result_t r;
		int nc, addr, nh, np, mr, mc;
		int hl [64], pl [64], rows [64], cols [64];
		longint amp;
		r = '0;
		nc = column_count();
		if (it.kind == KIND_WRITE) begin
			addr = int'(it.param_row) * nc + int'(it.param_col);
			if (it.param_row >= occ_cfg || it.param_col >= nc || addr >= DEPTH) begin
				r.status = ST_RANGE;
			end else begin
				param_mem[addr] = it.param_value;
				param_written[addr] = 1'b1;
			end
			return r;
		end
		if (it.kind != KIND_AMP && it.kind != KIND_DERIV) return r;
		split_mask(it.occupation_mask, nh, np, hl, pl);
		if (nh != np) begin
			r.status = ST_RANGE;
			return r;
		end
		if (nh > MAX_EXC) begin
			r.status = ST_EXC;
			return r;
		end
		if (it.kind == KIND_AMP) begin
			if (nh == 0) begin
				r.amplitude = ONE_Q30;
				return r;
			end
			r.status = ryser_sum(hl, pl, nh, amp);
			r.amplitude = amp;
			return r;
		end
		if (it.param_row >= occ_cfg || it.param_col >= nc) begin
			r.status = ST_RANGE;
			return r;
		end
		if (nh == 0) return r;
		mr = 0;
		mc = 0;
		for (int i = 0; i < nh; i++) begin
			if (hl[i] != it.param_row) begin
				rows[mr] = hl[i];
				mr++;
			end
			if (pl[i] != it.param_col) begin
				cols[mc] = pl[i];
				mc++;
			end
		end
		if (mr == 0 && mc == 0) begin
			r.amplitude = ONE_Q30;
			return r;
		end
		if (mr == nh || mc == nh || mr != mc) return r;
		r.status = ryser_sum(rows, cols, mr, amp);
		r.amplitude = amp;
		return r;
	endfunction

	// leaves start high but for random gaps; the caller issues the next beat in the same step or drops it
	task automatic issue(input item_t it, input bit typed, input result_t want);
		result_t predicted;
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = compute_amplitude(it);
		pending_amplitudes.insert(pending_amplitudes.size(), typed ? want : predicted);
		issued_count++;
		if (gaps_on && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// a query must never touch an entry that was never written
	task automatic fill_for_query(input item_t q);
		int nh, np, nc, addr;
		int hl [64], pl [64];
		item_t w;
		if (q.kind != KIND_AMP && q.kind != KIND_DERIV) return;
		split_mask(q.occupation_mask, nh, np, hl, pl);
		if (nh != np || nh > MAX_EXC) return;
		nc = column_count();
		for (int i = 0; i < nh; i++)
			for (int j = 0; j < nh; j++) begin
				addr = hl[i] * nc + pl[j];
				if (addr < DEPTH && !param_written[addr]) begin
					w = '0;
					w.kind = KIND_WRITE;
					w.param_row = 6'(hl[i]);
					w.param_col = 6'(pl[j]);
					w.param_value = $urandom;
					issue(w, 1'b0, '0);
				end
			end
	endtask

	task automatic set_geometry(input int occ, input int norb);
		start <= 1'b0;
		while (pending_amplitudes.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_OCC;
		cfg_data <= 7'(occ);
		@(posedge clk);
		cfg_index <= REG_NORB;
		cfg_data <= 7'(norb);
		@(posedge clk);
		cfg_we <= 1'b0;
		occ_cfg = occ & 63;
		norb_cfg = norb & 127;
		@(posedge clk);
	endtask

	function automatic item_t random_item();
		item_t it;
		int nc, mmax, m, b, pick;
		logic [63:0] holes, parts;
		it = '0;
		it.param_row = 6'($urandom);
		it.param_col = 6'($urandom);
		it.param_value = $urandom;
		it.occupation_mask = {$urandom, $urandom};
		nc = column_count();
		pick = $urandom_range(0, 99);
		it.kind = pick < 20 ? KIND_WRITE : pick < 75 ? KIND_AMP : pick < 95 ? KIND_DERIV : 2'd3;
		if (it.kind == KIND_WRITE) begin
			if ($urandom_range(0, 9) < 8) begin
				it.param_row = 6'($urandom_range(0, occ_cfg - 1));
				if (nc > 0) it.param_col = 6'($urandom_range(0, nc - 1));
			end
			return it;
		end
		if ($urandom_range(0, 9) < 2) begin
			// noise: random mask, or reference with one bit flipped
			if ($urandom_range(0, 1)) it.occupation_mask =
				((64'd1 << occ_cfg) - 64'd1) ^ (64'd1 << $urandom_range(0, 63));
			return it;
		end
		mmax = occ_cfg < nc ? occ_cfg : nc;
		pick = $urandom_range(0, 99);
		if (pick < 3 && mmax > MAX_EXC) m = MAX_EXC + 1;
		else if (pick < 8) m = $urandom_range(0, mmax < MAX_EXC ? mmax : MAX_EXC);
		else m = $urandom_range(0, mmax < 4 ? mmax : 4);
		holes = '0;
		parts = '0;
		for (int i = 0; i < m; i++) begin
			do b = $urandom_range(0, occ_cfg - 1); while (holes[b]);
			holes[b] = 1'b1;
			do b = $urandom_range(occ_cfg, occ_cfg + nc - 1); while (parts[b]);
			parts[b] = 1'b1;
		end
		it.occupation_mask = ((64'd1 << occ_cfg) - 64'd1) ^ holes ^ parts;
		// bits past the last orbital are don't-care
		if (norb_cfg < 64 && $urandom_range(0, 1))
			it.occupation_mask |= {$urandom, $urandom} & ~((64'd1 << norb_cfg) - 64'd1);
		if (it.kind == KIND_DERIV && $urandom_range(0, 9) < 7) begin
			if (m > 0 && $urandom_range(0, 3) != 0) begin
				for (int i = 0; i < 64; i++)
					if (holes[i] && $urandom_range(0, 1)) it.param_row = 6'(i);
				for (int i = 0; i < 64; i++)
					if (parts[i] && $urandom_range(0, 1)) it.param_col = 6'(i - occ_cfg);
			end
			if (it.param_row >= occ_cfg) it.param_row = 6'($urandom_range(0, occ_cfg - 1));
			if (nc > 0 && it.param_col >= nc) it.param_col = 6'($urandom_range(0, nc - 1));
		end
		return it;
	endfunction

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} stim_row_t;

	function automatic stim_row_t mk(input logic [1:0] kind, input logic [63:0] mask,
			input int row, input int col, input logic [31:0] val, input bit typed,
			input logic [63:0] amp, input logic [1:0] st);
		stim_row_t s;
		s.it.kind = kind;
		s.it.occupation_mask = mask;
		s.it.param_row = 6'(row);
		s.it.param_col = 6'(col);
		s.it.param_value = val;
		s.typed = typed;
		s.want.amplitude = amp;
		s.want.status = st;
		return s;
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (done) begin
			if (pending_amplitudes.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				exp_r = pending_amplitudes.pop_front();
				if (result.amplitude !== exp_r.amplitude)
					report($sformatf("amplitude %h, expected %h",
						result.amplitude, exp_r.amplitude));
				if (result.status !== exp_r.status)
					report($sformatf("status %0d, expected %0d", result.status, exp_r.status));
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("tb_ryser_permanent_amplitude NOT OK");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t row_s;
		item_t it;
		int base;
		int geo [8][2];
		geo = '{'{1, 64}, '{63, 64}, '{63, 2}, '{8, 16},
			'{32, 64}, '{5, 12}, '{20, 30}, '{12, 64}};
		for (int a = 0; a < DEPTH; a++) begin
			param_mem[a] = '0;
			param_written[a] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: one occupied orbital, 63 virtual columns
		rows = {rows, mk(KIND_AMP, 64'h1, 0, 0, '0, 1'b1, ONE_Q30, ST_OK)};
		rows = {rows, mk(2'd3, '1, 63, 63, '1, 1'b1, '0, ST_OK)};
		rows = {rows, mk(KIND_WRITE, '0, 0, 0, 32'h7fff_ffff, 1'b1, '0, ST_OK)};
		rows = {rows, mk(KIND_WRITE, '0, 1, 0, 32'h1234_5678, 1'b1, '0, ST_RANGE)};
		rows = {rows, mk(KIND_WRITE, '0, 0, 63, 32'h1, 1'b1, '0, ST_RANGE)};
		rows = {rows, mk(KIND_WRITE, '0, 0, 62, 32'h8000_0000, 1'b1, '0, ST_OK)};
		rows = {rows, mk(KIND_AMP, 64'h2, 0, 0, '0, 1'b0, '0, ST_OK)};
		rows = {rows, mk(KIND_AMP, 64'h8000_0000_0000_0000, 0, 0, '0, 1'b0, '0, ST_OK)};
		rows = {rows, mk(KIND_AMP, 64'h0, 0, 0, '0, 1'b1, '0, ST_RANGE)};
		rows = {rows, mk(KIND_AMP, 64'h3, 0, 0, '0, 1'b1, '0, ST_RANGE)};
		rows = {rows, mk(KIND_DERIV, 64'h2, 0, 0, '0, 1'b1, ONE_Q30, ST_OK)};
		rows = {rows, mk(KIND_DERIV, 64'h2, 0, 5, '0, 1'b1, '0, ST_OK)};
		rows = {rows, mk(KIND_DERIV, 64'h1, 0, 0, '0, 1'b1, '0, ST_OK)};
		rows = {rows, mk(KIND_DERIV, 64'h2, 1, 0, '0, 1'b1, '0, ST_RANGE)};
		rows = {rows, mk(KIND_DERIV, 64'h2, 0, 63, '0, 1'b1, '0, ST_RANGE)};
		foreach (rows[i]) issue(rows[i].it, rows[i].typed, rows[i].want);

		for (int p = 0; p < 8; p++) begin
			gaps_on = !(p == 1 || p == 4);
			set_geometry(geo[p][0], geo[p][1]);
			if (p == 3) begin
				// full matrix at -2.0, then the full eight-fold excitation
				for (int r = 0; r < 8; r++)
					for (int c = 0; c < 8; c++) begin
						row_s = mk(KIND_WRITE, '0, r, c, 32'h8000_0000, 1'b0, '0, ST_OK);
						issue(row_s.it, 1'b0, '0);
					end
				row_s = mk(KIND_AMP, 64'hff00, 0, 0, '0, 1'b0, '0, ST_OK);
				issue(row_s.it, 1'b0, '0);
				row_s = mk(KIND_DERIV, 64'hff00, 7, 0, '0, 1'b0, '0, ST_OK);
				issue(row_s.it, 1'b0, '0);
			end
			base = issued_count;
			while (issued_count < base + ITEMS_PER_GEO) begin
				it = random_item();
				fill_for_query(it);
				issue(it, 1'b0, '0);
			end
		end
		start <= 1'b0;

		while (pending_amplitudes.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_ryser_permanent_amplitude OK");
		end else begin
			$display("tb_ryser_permanent_amplitude NOT OK");
		end
		$finish;
	end

endmodule
